// ===== hdl/qfs_pkg.sv =====
package qfs_pkg;

  // metadata sits in the low bits of a slot, remainder above it
  localparam int META_BITS = 4;
  localparam int OCC_BIT   = 3;
  localparam int CONT_BIT  = 2;
  localparam int SHIFT_BIT = 1;

  // occupied flag; the other flags follow it downwards
  localparam logic [META_BITS-1:0] FLAG_TOP = 4'b1000;

  localparam int CELL_OUT_W  = 12;
  localparam int INDEX_W     = 10;
  localparam int RUN_COUNT_W = 11;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_FLAG   = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_EMPTY  = 3'd4
  } cmd_t;

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_EVAL     = 8'b0000_0100,
    S_BACK     = 8'b0000_1000,
    S_FWD_RUN  = 8'b0001_0000,
    S_FWD_CONT = 8'b0010_0000,
    S_SCAN     = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

endpackage

// ===== hdl/qfs_ram.sv =====
module qfs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/quotient_filter_slot_store.sv =====
// Slot table of a quotient filter: 2^CAPACITY_LOG2 slots in one synchronous RAM, each a
// remainder above the occupied, continuation, shifted and false-positive flags. One item
// is worked at a time and gives one result. Read, write and flag commands pass from idle
// through evaluation and done back to idle; done holds while the output is not free.
// Locate run returns the addressed slot itself if it is empty; otherwise it steps back to
// the cluster start, then advances run by run, skipping continuation slots. Next empty
// walks forward over non-empty slots to the first empty one. Every walk step is one read
// of the slot RAM, which has a single read port, so walks move one slot at a time and
// stop after 2^CAPACITY_LOG2 steps with status set. After reset a clearing pass writes
// every slot to zero with in_ready low.
module quotient_filter_slot_store
  import qfs_pkg::*;
#(
  parameter int CAPACITY_LOG2  = 10,
  parameter int REMAINDER_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             command,
  input  logic [INDEX_W-1:0]     slot_index,
  input  logic [CELL_OUT_W-1:0]  slot_value,
  input  logic [1:0]             flag_select,
  input  logic                   flag_on,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CELL_OUT_W-1:0]  cell_value,
  output logic [INDEX_W-1:0]     found_slot,
  output logic [RUN_COUNT_W-1:0] run_count,
  output logic                   status
);

  localparam int IDX_W  = CAPACITY_LOG2;
  localparam int CNT_W  = CAPACITY_LOG2 + 1;
  localparam int CELL_W = REMAINDER_BITS + META_BITS;
  localparam logic [IDX_W-1:0] IDX_ONE = 1;
  localparam logic [CNT_W-1:0] CNT_ONE = 1;

  state_t            state, state_next;
  cmd_t              cmd;
  logic [IDX_W-1:0]  orig_idx;
  logic [CELL_W-1:0] wval;
  logic [1:0]        sel;
  logic              on;

  logic [IDX_W-1:0]  pos, pos_next;
  logic [CNT_W-1:0]  steps, steps_next;
  logic [CNT_W-1:0]  occ_cnt, occ_cnt_next;
  logic [CNT_W-1:0]  run_cnt, run_cnt_next;
  logic [CELL_W-1:0] res_cell, res_cell_next;
  logic [IDX_W-1:0]  res_found, res_found_next;
  logic              res_status, res_status_next;

  logic              wr_en;
  logic [CELL_W-1:0] wr_data;
  logic [CELL_W-1:0] rd_data;
  logic [CELL_W-1:0] flag_cell;
  logic [CELL_W-1:0] flag_mask;

  logic [META_BITS-1:0] cur_meta;
  logic cur_empty, cur_occ, cur_cont, cur_shift, cur_run_start, cur_cstart;
  logic accept, out_free;

  qfs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (1 << CAPACITY_LOG2)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_data (wr_data),
    .rd_addr (pos_next),
    .rd_data (rd_data)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // rd_data holds the slot at pos, as read before a write to it lands: the read address follows pos_next
  assign cur_meta      = rd_data[META_BITS-1:0];
  assign cur_empty     = (cur_meta == '0);
  assign cur_occ       = cur_meta[OCC_BIT];
  assign cur_cont      = cur_meta[CONT_BIT];
  assign cur_shift     = cur_meta[SHIFT_BIT];
  assign cur_run_start = !cur_empty && !cur_cont;
  assign cur_cstart    = !cur_cont && !cur_shift;

  assign flag_mask = CELL_W'(FLAG_TOP >> sel);
  assign flag_cell = on ? (rd_data | flag_mask) : (rd_data & ~flag_mask);

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    steps_next      = steps;
    occ_cnt_next    = occ_cnt;
    run_cnt_next    = run_cnt;
    res_cell_next   = res_cell;
    res_found_next  = res_found;
    res_status_next = res_status;
    wr_en           = 1'b0;
    wr_data         = wval;
    unique case (state)
      S_CLEAR: begin
        wr_en    = 1'b1;
        wr_data  = '0;
        pos_next = pos + IDX_ONE;
        if (&pos) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          pos_next        = IDX_W'(slot_index);
          steps_next      = '0;
          occ_cnt_next    = '0;
          run_cnt_next    = '0;
          res_cell_next   = '0;
          res_found_next  = '0;
          res_status_next = 1'b0;
          state_next      = S_EVAL;
        end
      end
      S_EVAL: begin
        unique case (cmd)
          CMD_READ: begin
            res_cell_next = rd_data;
            state_next    = S_DONE;
          end
          CMD_WRITE: begin
            wr_en         = 1'b1;
            res_cell_next = wval;
            state_next    = S_DONE;
          end
          CMD_FLAG: begin
            wr_en         = 1'b1;
            wr_data       = flag_cell;
            res_cell_next = flag_cell;
            state_next    = S_DONE;
          end
          CMD_LOCATE: begin
            priority if (cur_empty) begin
              res_found_next = pos;
              state_next     = S_DONE;
            end else if (cur_cstart) begin
              state_next = S_FWD_RUN;
            end else begin
              pos_next   = pos - IDX_ONE;
              steps_next = CNT_ONE;
              state_next = S_BACK;
            end
          end
          CMD_EMPTY: begin
            state_next = S_SCAN;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_BACK: begin
        // occupied flags of the slots stepped onto name the runs to skip
        occ_cnt_next = occ_cnt + CNT_W'(cur_occ);
        priority if (cur_cstart) begin
          steps_next = '0;
          state_next = S_FWD_RUN;
        end else if (steps[IDX_W]) begin
          res_found_next  = orig_idx;
          res_status_next = 1'b1;
          state_next      = S_DONE;
        end else begin
          pos_next   = pos - IDX_ONE;
          steps_next = steps + CNT_ONE;
        end
      end
      S_FWD_RUN: begin
        priority if (occ_cnt == '0) begin
          res_found_next = pos;
          state_next     = S_DONE;
        end else if (cur_run_start && steps[IDX_W]) begin
          res_found_next  = orig_idx;
          res_status_next = 1'b1;
          state_next      = S_DONE;
        end else if (cur_run_start) begin
          pos_next   = pos + IDX_ONE;
          steps_next = steps + CNT_ONE;
          state_next = S_FWD_CONT;
        end else begin
          state_next = S_FWD_CONT;
        end
      end
      S_FWD_CONT: begin
        priority if (!cur_cont) begin
          occ_cnt_next = occ_cnt - CNT_ONE;
          state_next   = S_FWD_RUN;
        end else if (steps[IDX_W]) begin
          res_found_next  = orig_idx;
          res_status_next = 1'b1;
          state_next      = S_DONE;
        end else begin
          pos_next   = pos + IDX_ONE;
          steps_next = steps + CNT_ONE;
        end
      end
      S_SCAN: begin
        priority if (cur_empty) begin
          res_found_next = pos;
          state_next     = S_DONE;
        end else if (steps[IDX_W]) begin
          res_found_next  = orig_idx;
          res_status_next = 1'b1;
          state_next      = S_DONE;
        end else begin
          run_cnt_next = run_cnt + CNT_W'(cur_run_start);
          pos_next     = pos + IDX_ONE;
          steps_next   = steps + CNT_ONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    steps      <= steps_next;
    occ_cnt    <= occ_cnt_next;
    run_cnt    <= run_cnt_next;
    res_cell   <= res_cell_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
    if (accept) begin
      cmd      <= cmd_t'(command);
      orig_idx <= IDX_W'(slot_index);
      wval     <= CELL_W'(slot_value);
      sel      <= flag_select;
      on       <= flag_on;
    end
    if (state == S_DONE && out_free) begin
      cell_value <= CELL_OUT_W'(res_cell);
      found_slot <= INDEX_W'(res_found);
      run_count  <= RUN_COUNT_W'(run_cnt);
      status     <= res_status;
    end
  end

`ifndef SYNTHESIS
  // walk step counter never passes the table size
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_BACK || state == S_FWD_RUN || state == S_FWD_CONT || state == S_SCAN)
      && steps[IDX_W] |-> steps[IDX_W-1:0] == '0)
    else $error("walk step counter beyond table size");

  // a failed walk reports the addressed slot
  a_fail_found: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && res_status |-> res_found == orig_idx)
    else $error("failed walk with wrong found slot");

  // the table is written only by the clearing pass or a write or flag command
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == S_CLEAR
      || (state == S_EVAL && (cmd == CMD_WRITE || cmd == CMD_FLAG)))
    else $error("unexpected table write");

  // a new result appears only when an item finishes
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result shown without a finished item");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qfs_pkg::*;

  localparam int SLOTS         = 1 << INDEX_W;
  localparam int RANDOM_ITEMS  = 800;
  localparam int IDLE_PCT      = 18;
  localparam int QUIET_FROM    = 400;
  localparam int QUIET_TO      = 650;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_CYCLES    = 5_000_000;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  localparam logic [1:0] SEL_OCC   = 2'd0;
  localparam logic [1:0] SEL_CONT  = 2'd1;
  localparam logic [1:0] SEL_SHIFT = 2'd2;
  localparam logic [1:0] SEL_FP    = 2'd3;

  localparam logic [META_BITS-1:0] META_NONE = 4'b0000;
  localparam logic [META_BITS-1:0] META_HEAD = 4'b1000;
  localparam logic [META_BITS-1:0] META_TAIL = 4'b1110;

  typedef struct packed {
    logic [2:0]            command;
    logic [INDEX_W-1:0]    index;
    logic [CELL_OUT_W-1:0] value;
    logic [1:0]            sel;
    logic                  on;
  } slot_cmd_t;

  typedef struct packed {
    logic [CELL_OUT_W-1:0]  content;
    logic [INDEX_W-1:0]     found;
    logic [RUN_COUNT_W-1:0] runs;
    logic                   status;
  } slot_reply_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [2:0]             command = '0;
  logic [INDEX_W-1:0]     slot_index = '0;
  logic [CELL_OUT_W-1:0]  slot_value = '0;
  logic [1:0]             flag_select = '0;
  logic                   flag_on = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CELL_OUT_W-1:0]  cell_value;
  logic [INDEX_W-1:0]     found_slot;
  logic [RUN_COUNT_W-1:0] run_count;
  logic                   status;

  slot_cmd_t   cmd_backlog[$];
  slot_reply_t replies_due[$];
  logic [CELL_OUT_W-1:0] slot_mem [SLOTS] = '{default: '0};

  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_errors = 0;
  int  n_replies = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  in_fired = 1'b0;
  bit  quiet;

  quotient_filter_slot_store #(
    .CAPACITY_LOG2 (INDEX_W),
    .REMAINDER_BITS(CELL_OUT_W - META_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .slot_index (slot_index),
    .slot_value (slot_value),
    .flag_select(flag_select),
    .flag_on    (flag_on),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_value (cell_value),
    .found_slot (found_slot),
    .run_count  (run_count),
    .status     (status)
  );

  always #5 clk = ~clk;

  assign quiet = (n_accepted >= QUIET_FROM) && (n_accepted < QUIET_TO);

  // slot table mirror

  function automatic logic [META_BITS-1:0] meta_at(input logic [INDEX_W-1:0] i);
    return slot_mem[i][META_BITS-1:0];
  endfunction

  function automatic bit is_blank(input logic [INDEX_W-1:0] i);
    return meta_at(i) == META_NONE;
  endfunction

  function automatic bit is_cont(input logic [INDEX_W-1:0] i);
    return meta_at(i)[CONT_BIT];
  endfunction

  function automatic bit is_run_head(input logic [INDEX_W-1:0] i);
    return !is_blank(i) && !is_cont(i);
  endfunction

  function automatic bit is_cluster_head(input logic [INDEX_W-1:0] i);
    return !meta_at(i)[CONT_BIT] && !meta_at(i)[SHIFT_BIT];
  endfunction

  // back to the cluster start counting occupied quotients, then forward that many runs
  function automatic bit find_run(input logic [INDEX_W-1:0] q, output logic [INDEX_W-1:0] pos);
    logic [INDEX_W-1:0] idx;
    int occupied;
    int steps;
    int n;
    idx = q;
    occupied = 0;
    steps = 0;
    pos = q;
    if (is_blank(idx)) return 1'b1;
    while (!is_cluster_head(idx)) begin
      if (steps >= SLOTS) return 1'b0;
      idx = idx - 1'b1;
      steps++;
      if (meta_at(idx)[OCC_BIT]) occupied++;
    end
    steps = 0;
    for (n = 0; n < occupied; n++) begin
      if (is_run_head(idx)) begin
        if (steps >= SLOTS) return 1'b0;
        idx = idx + 1'b1;
        steps++;
      end
      while (is_cont(idx)) begin
        if (steps >= SLOTS) return 1'b0;
        idx = idx + 1'b1;
        steps++;
      end
    end
    pos = idx;
    return 1'b1;
  endfunction

  function automatic slot_reply_t apply_slot_cmd(input slot_cmd_t c);
    slot_reply_t r;
    logic [META_BITS-1:0] mask;
    logic [INDEX_W-1:0] p;
    int steps;
    int heads;
    bit ok;
    r = '0;
    case (c.command)
      CMD_READ: r.content = slot_mem[c.index];
      CMD_WRITE: begin
        slot_mem[c.index] = c.value;
        r.content = c.value;
      end
      CMD_FLAG: begin
        mask = FLAG_TOP >> c.sel;
        if (c.on) slot_mem[c.index][META_BITS-1:0] = meta_at(c.index) | mask;
        else slot_mem[c.index][META_BITS-1:0] = meta_at(c.index) & ~mask;
        r.content = slot_mem[c.index];
      end
      CMD_LOCATE: begin
        ok = find_run(c.index, p);
        r.found = ok ? p : c.index;
        r.status = !ok;
      end
      CMD_EMPTY: begin
        p = c.index;
        steps = 0;
        heads = 0;
        while (!is_blank(p)) begin
          if (steps >= SLOTS) begin
            r.status = 1'b1;
            break;
          end
          if (is_run_head(p)) heads++;
          p = p + 1'b1;
          steps++;
        end
        r.found = r.status ? c.index : p;
        r.runs = RUN_COUNT_W'(heads);
      end
      default: ;
    endcase
    return r;
  endfunction

  // stimulus helpers

  function automatic logic [CELL_OUT_W-1:0] with_meta(input logic [CELL_OUT_W-1:0] raw,
                                                       input logic [META_BITS-1:0] meta);
    return {raw[CELL_OUT_W-1:META_BITS], meta};
  endfunction

  task automatic add_item(input logic [2:0] c, input logic [INDEX_W-1:0] idx,
                          input logic [CELL_OUT_W-1:0] val, input logic [1:0] sel,
                          input logic on);
    cmd_backlog.push_back('{c, idx, val, sel, on});
    n_queued++;
  endtask

  task automatic add_query(input logic [2:0] c, input logic [INDEX_W-1:0] idx);
    add_item(c, idx, CELL_OUT_W'($urandom), 2'($urandom), 1'($urandom));
  endtask

  // driver: new item at the falling edge once the previous one is taken
  always @(negedge clk) begin : drive_items
    slot_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (cmd_backlog.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = cmd_backlog.pop_front();
        in_valid    <= 1'b1;
        command     <= nxt.command;
        slot_index  <= nxt.index;
        slot_value  <= nxt.value;
        flag_select <= nxt.sel;
        flag_on     <= nxt.on;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the input backs up
  always @(negedge clk) begin : drain_results
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin : check_results
    slot_reply_t got;
    slot_reply_t want;
    in_fired <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      replies_due.push_back(apply_slot_cmd('{command, slot_index, slot_value,
                                             flag_select, flag_on}));
      n_accepted++;
    end
    if (!rst && out_valid && out_ready) begin
      got = '{cell_value, found_slot, run_count, status};
      if (replies_due.size() == 0) begin
        if (n_errors < REPORT_LIMIT)
          $display("unexpected result %0d: slot %h found %0d runs %0d status %0d",
                   n_replies, got.content, got.found, got.runs, got.status);
        n_errors++;
      end else begin
        want = replies_due.pop_front();
        if (got !== want) begin
          if (n_errors < REPORT_LIMIT)
            $display("mismatch on result %0d: exp %h %0d %0d %0d, got %h %0d %0d %0d",
                     n_replies, want.content, want.found, want.runs, want.status,
                     got.content, got.found, got.runs, got.status);
          n_errors++;
        end
      end
      n_replies++;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [INDEX_W-1:0] base;
    logic [2:0] c;
    logic occ;
    logic cont;
    logic shift;
    int len;
    int j;
    int k;
    int roll;
    int first;

    // directed: empty table, a small cluster across the wrap, flag set and clear, spare command codes
    add_query(CMD_READ, '0);
    add_query(CMD_LOCATE, 10'd5);
    add_query(CMD_EMPTY, INDEX_W'(SLOTS - 1));
    add_item(CMD_WRITE, INDEX_W'(SLOTS - 1), 12'hFFF, SEL_FP, 1'b1);
    add_query(CMD_READ, INDEX_W'(SLOTS - 1));
    add_item(CMD_WRITE, INDEX_W'(SLOTS - 2), with_meta(12'h110, META_HEAD), SEL_OCC, 1'b0);
    add_item(CMD_WRITE, INDEX_W'(SLOTS - 1), with_meta(12'hFF0, META_TAIL), SEL_CONT, 1'b0);
    add_item(CMD_WRITE, 10'd0, with_meta(12'h000, 4'b0011), SEL_SHIFT, 1'b0);
    add_item(CMD_WRITE, 10'd1, with_meta(12'h5A0, 4'b0110), SEL_FP, 1'b0);
    add_item(CMD_FLAG, 10'd0, 12'h000, SEL_OCC, 1'b1);
    add_item(CMD_FLAG, 10'd2, 12'hFFF, SEL_FP, 1'b1);
    add_item(CMD_FLAG, 10'd0, 12'h000, SEL_FP, 1'b0);
    add_item(CMD_FLAG, 10'd2, 12'hFFF, SEL_CONT, 1'b0);
    add_item(CMD_FLAG, 10'd5, 12'h000, SEL_CONT, 1'b1);
    add_item(CMD_FLAG, 10'd5, 12'hFFF, SEL_SHIFT, 1'b1);
    add_item(CMD_FLAG, 10'd5, 12'h000, SEL_CONT, 1'b0);
    add_query(CMD_LOCATE, INDEX_W'(SLOTS - 1));
    add_query(CMD_LOCATE, 10'd0);
    add_query(CMD_LOCATE, 10'd1);
    add_query(CMD_LOCATE, 10'd5);
    add_query(CMD_EMPTY, INDEX_W'(SLOTS - 2));
    for (k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++)
      add_item(3'(k), '1, '1, SEL_FP, 1'b1);
    add_item(CMD_WRITE, 10'd300, '0, SEL_OCC, 1'b0);
    add_query(CMD_READ, 10'd300);

    // random: mostly well-formed clusters followed by walks into them, some noise
    first = n_queued;
    while (n_queued - first < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 55) begin
        base = $urandom_range(1) ? INDEX_W'(SLOTS - 24 + $urandom_range(23))
                                 : INDEX_W'($urandom);
        len = $urandom_range(1, 12);
        for (j = 0; j < len; j++) begin
          if (j == 0) begin
            occ = $urandom_range(99) < 85;
            cont = 1'b0;
            shift = 1'b0;
          end else begin
            occ = $urandom_range(99) < 60;
            cont = $urandom_range(99) >= 35;
            shift = 1'b1;
          end
          add_item(CMD_WRITE, base + INDEX_W'(j),
                   with_meta(CELL_OUT_W'($urandom), {occ, cont, shift, 1'($urandom)}),
                   2'($urandom), 1'($urandom));
        end
        if ($urandom_range(99) < 30)
          add_item(CMD_WRITE, base + INDEX_W'(len), with_meta(CELL_OUT_W'($urandom), META_NONE),
                   2'($urandom), 1'($urandom));
        repeat ($urandom_range(2, 4)) begin
          roll = $urandom_range(99);
          c = roll < 45 ? CMD_LOCATE : roll < 75 ? CMD_EMPTY : roll < 90 ? CMD_READ : CMD_FLAG;
          add_query(c, base + INDEX_W'($urandom_range(len)));
        end
      end else begin
        if ($urandom_range(99) < 10) c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        else c = 3'($urandom_range(CMD_READ, CMD_EMPTY));
        add_query(c, INDEX_W'($urandom));
      end
    end

    // full table: one cluster head, every other slot a shifted continuation
    for (k = 0; k < SLOTS; k++)
      add_item(CMD_WRITE, INDEX_W'(k),
               with_meta(CELL_OUT_W'($urandom), (k == 0) ? META_HEAD : META_TAIL),
               2'($urandom), 1'($urandom));
    add_query(CMD_EMPTY, INDEX_W'($urandom));
    add_query(CMD_LOCATE, 10'd5);
    add_query(CMD_LOCATE, 10'd0);
    add_query(CMD_READ, INDEX_W'($urandom));
    // no cluster start left anywhere
    add_item(CMD_FLAG, 10'd0, CELL_OUT_W'($urandom), SEL_SHIFT, 1'b1);
    add_query(CMD_LOCATE, INDEX_W'($urandom));
    add_query(CMD_EMPTY, INDEX_W'($urandom));
    add_item(CMD_FLAG, 10'd0, CELL_OUT_W'($urandom), SEL_CONT, 1'b1);
    add_query(CMD_EMPTY, INDEX_W'($urandom));
    // one hole, reached only after wrapping
    add_item(CMD_WRITE, 10'd700, with_meta(CELL_OUT_W'($urandom), META_NONE), SEL_OCC, 1'b1);
    add_query(CMD_EMPTY, 10'd701);
    add_query(CMD_LOCATE, 10'd699);
    add_query(CMD_LOCATE, 10'd701);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_accepted < n_queued || replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
